// ===== design/fpfa_pkg.sv =====
// Shared types and codes of the fixed-partition fit allocator.
// Used by fpfa_cell and fixed_partition_fit_allocator; no dependencies.
`default_nettype none

package fpfa_pkg;

  // Port widths of the item and result words
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned IDX_PORT_W  = 4;
  localparam int unsigned SIZE_PORT_W = 16;
  localparam int unsigned BNUM_W      = 5;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned BIU_W       = 5;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 5;

  // Command codes of an input word
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_ALLOC = 2'd2
  } cmd_t;

  // Search policy codes; any other code acts as first fit
  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 1'd1;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SEARCH = 2'd1,
    ST_REPLY  = 2'd2
  } state_t;

  // Policy broadcast to every cell; neither bit set means first fit
  typedef struct packed {
    logic best;
    logic worst;
  } fit_ctl_t;

endpackage

`default_nettype wire

// ===== design/fpfa_cell.sv =====
// One partition cell: holds a block size and its taken flag, and refines the
// running candidate handed on from its left neighbor. Depends on fpfa_pkg.
`default_nettype none

module fpfa_cell #(
  parameter int unsigned IDX_W    = 4,
  parameter int unsigned SIZE_W   = 16,
  parameter int unsigned CELL_IDX = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 load_en,
  input  wire logic [SIZE_W-1:0]    load_value,
  input  wire logic                 clear_en,
  input  wire logic                 set_taken,
  input  wire logic                 search_en,
  input  wire fpfa_pkg::fit_ctl_t   fit_ctl,
  input  wire logic [SIZE_W-1:0]    req,
  input  wire logic                 cand_found_in,
  input  wire logic [IDX_W-1:0]     cand_idx_in,
  input  wire logic [SIZE_W-1:0]    cand_size_in,
  output logic                      cand_found_out,
  output logic [IDX_W-1:0]          cand_idx_out,
  output logic [SIZE_W-1:0]         cand_size_out,
  output logic                      taken
);

  logic [SIZE_W-1:0] size_r;
  logic              taken_r;
  logic              found_r;
  logic [IDX_W-1:0]  idx_r;
  logic [SIZE_W-1:0] csize_r;

  logic              fits;
  logic              take;

  // Store the partition size on a load
  always_ff @(posedge clk) begin
    if (load_en) begin
      size_r <= load_value;
    end
  end

  // Clear wins over a grant; both never come together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taken_r <= 1'b0;
    end else if (clear_en) begin
      taken_r <= 1'b0;
    end else if (set_taken) begin
      taken_r <= 1'b1;
    end
  end

  // Replace the candidate when this block is free, large enough and better
  always_comb begin
    fits = search_en && !taken_r && (size_r >= req);
    take = fits && (!cand_found_in ||
                    (fit_ctl.best  && (size_r < cand_size_in)) ||
                    (fit_ctl.worst && (size_r > cand_size_in)));
  end

  // Hand the candidate to the right neighbor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= cand_found_in || fits;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= take ? IDX_W'(CELL_IDX) : cand_idx_in;
    csize_r <= take ? size_r : cand_size_in;
  end

  assign cand_found_out = found_r;
  assign cand_idx_out   = idx_r;
  assign cand_size_out  = csize_r;
  assign taken          = taken_r;

endmodule

`default_nettype wire

// ===== design/fixed_partition_fit_allocator.sv =====
// Fixed-partition allocator: first, best or worst fit over a chain of cells.
// Load and clear words go straight to the reply state. Allocate words: the
// candidate ripples one cell per cycle through the chain during the search.
// One word at a time; a new word is taken only once the last result is loaded.
// Synchronous active-low reset frees every block, fit mode first fit and
// 16 blocks in use; block sizes are undefined until loaded.
`default_nettype none

module fixed_partition_fit_allocator #(
  parameter int unsigned MAX_BLOCKS = 16,
  parameter int unsigned SIZE_BITS  = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // Configuration port
  input  wire logic                                 cfg_we,
  input  wire logic [fpfa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [fpfa_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // Input channel
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [fpfa_pkg::CMD_W-1:0]           in_command,
  input  wire logic [fpfa_pkg::IDX_PORT_W-1:0]      in_block_index,
  input  wire logic [fpfa_pkg::SIZE_PORT_W-1:0]     in_block_size_value,
  input  wire logic [fpfa_pkg::SIZE_PORT_W-1:0]     in_request_size,
  input  wire logic                                 in_batch_end,
  // Result channel
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic                                      out_granted,
  output logic [fpfa_pkg::BNUM_W-1:0]               out_block_number,
  output logic [fpfa_pkg::SIZE_PORT_W-1:0]          out_granted_block_size,
  output logic [fpfa_pkg::SIZE_PORT_W-1:0]          out_leftover,
  output logic                                      out_batch_done
);

  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS);

  // Configuration registers
  logic [fpfa_pkg::MODE_W-1:0] fit_mode_r;
  logic [fpfa_pkg::BIU_W-1:0]  blocks_in_use_r;

  // Controller
  fpfa_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             in_accept;
  logic             reply_fire;
  logic             is_alloc_r;
  logic [SIZE_BITS-1:0] req_r;
  logic             bend_r;
  fpfa_pkg::fit_ctl_t fit_ctl;

  // Chain wiring
  logic                 found_c [MAX_BLOCKS+1];
  logic [IDX_W-1:0]     idx_c   [MAX_BLOCKS+1];
  logic [SIZE_BITS-1:0] size_c  [MAX_BLOCKS+1];
  logic [MAX_BLOCKS-1:0] taken_vec;
  logic [SIZE_BITS-1:0] load_value;
  logic                 grant_now;

  // Output register
  logic                           out_valid_r;
  logic                           out_granted_r;
  logic [fpfa_pkg::BNUM_W-1:0]    out_block_number_r;
  logic [fpfa_pkg::SIZE_PORT_W-1:0] out_size_r;
  logic [fpfa_pkg::SIZE_PORT_W-1:0] out_leftover_r;
  logic                           out_batch_done_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r      <= fpfa_pkg::MODE_FIRST;
      blocks_in_use_r <= fpfa_pkg::BIU_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        fpfa_pkg::CFG_FIT_MODE:      fit_mode_r      <= cfg_wdata[fpfa_pkg::MODE_W-1:0];
        fpfa_pkg::CFG_BLOCKS_IN_USE: blocks_in_use_r <= cfg_wdata[fpfa_pkg::BIU_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    fit_ctl.best  = (fit_mode_r == fpfa_pkg::MODE_BEST);
    fit_ctl.worst = (fit_mode_r == fpfa_pkg::MODE_WORST);
  end

  assign in_stall   = (state_r != fpfa_pkg::ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign reply_fire = (state_r == fpfa_pkg::ST_REPLY) && (!out_valid_r || !out_stall);
  assign load_value = SIZE_BITS'(in_block_size_value);

  // Next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      fpfa_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (in_command == fpfa_pkg::CMD_ALLOC) begin
            state_nxt = fpfa_pkg::ST_SEARCH;
          end else begin
            state_nxt = fpfa_pkg::ST_REPLY;
          end
        end
      end
      fpfa_pkg::ST_SEARCH: begin
        if (cnt_r == CNT_W'(MAX_BLOCKS - 1)) begin
          state_nxt = fpfa_pkg::ST_REPLY;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      fpfa_pkg::ST_REPLY: begin
        if (reply_fire) begin
          state_nxt = fpfa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fpfa_pkg::ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fpfa_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Hold the accepted word for the search and the reply
  always_ff @(posedge clk) begin
    if (in_accept) begin
      is_alloc_r <= (in_command == fpfa_pkg::CMD_ALLOC);
      req_r      <= SIZE_BITS'(in_request_size);
      bend_r     <= in_batch_end;
    end
  end

  // Grant when the chain end holds a candidate for an allocate
  assign grant_now = reply_fire && is_alloc_r && found_c[MAX_BLOCKS];

  // Cell chain; the left end enters with no candidate
  assign found_c[0] = 1'b0;
  assign idx_c[0]   = '0;
  assign size_c[0]  = '0;

  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    logic load_hit;
    logic grant_hit;
    logic in_use;

    assign load_hit  = in_accept && (in_command == fpfa_pkg::CMD_LOAD) &&
                       (32'(in_block_index) == i);
    assign grant_hit = grant_now && (32'(idx_c[MAX_BLOCKS]) == i);
    assign in_use    = (i < 32'(blocks_in_use_r));

    fpfa_cell #(
      .IDX_W    (IDX_W),
      .SIZE_W   (SIZE_BITS),
      .CELL_IDX (i)
    ) u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .load_en        (load_hit),
      .load_value     (load_value),
      .clear_en       (in_accept && (in_command == fpfa_pkg::CMD_CLEAR)),
      .set_taken      (grant_hit),
      .search_en      (in_use),
      .fit_ctl        (fit_ctl),
      .req            (req_r),
      .cand_found_in  (found_c[i]),
      .cand_idx_in    (idx_c[i]),
      .cand_size_in   (size_c[i]),
      .cand_found_out (found_c[i+1]),
      .cand_idx_out   (idx_c[i+1]),
      .cand_size_out  (size_c[i+1]),
      .taken          (taken_vec[i])
    );
  end

  // Load the result word; drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (reply_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (reply_fire) begin
      out_batch_done_r <= bend_r;
      if (is_alloc_r && found_c[MAX_BLOCKS]) begin
        out_granted_r      <= 1'b1;
        out_block_number_r <= fpfa_pkg::BNUM_W'({1'b0, idx_c[MAX_BLOCKS]} + 1'b1);
        out_size_r         <= fpfa_pkg::SIZE_PORT_W'(size_c[MAX_BLOCKS]);
        out_leftover_r     <= fpfa_pkg::SIZE_PORT_W'(size_c[MAX_BLOCKS] - req_r);
      end else begin
        out_granted_r      <= 1'b0;
        out_block_number_r <= '0;
        out_size_r         <= '0;
        out_leftover_r     <= '0;
      end
    end
  end

  assign out_valid              = out_valid_r;
  assign out_granted            = out_granted_r;
  assign out_block_number       = out_block_number_r;
  assign out_granted_block_size = out_size_r;
  assign out_leftover           = out_leftover_r;
  assign out_batch_done         = out_batch_done_r;

  // An allocate's candidate at the chain end is always a free block
  a_cand_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fpfa_pkg::ST_REPLY && is_alloc_r && found_c[MAX_BLOCKS])
      |-> !taken_vec[idx_c[MAX_BLOCKS]])
    else $error("chosen block already taken");

  // A grant never hands out a block smaller than the request
  a_grant_fits: assert property (@(posedge clk) disable iff (!rst_n)
    grant_now |-> (size_c[MAX_BLOCKS] >= req_r))
    else $error("granted block smaller than request");

  // A granted result carries a nonzero block number
  a_bnum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_granted_r) |-> (out_block_number_r != '0))
    else $error("grant with block number zero");

  // The walk counter rests outside the search
  a_cnt_rest: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != fpfa_pkg::ST_SEARCH) |-> (cnt_r == '0))
    else $error("walk counter running outside search");

  // A granted block reads as taken in the next cycle
  a_mark: assert property (@(posedge clk) disable iff (!rst_n)
    grant_now |=> taken_vec[$past(idx_c[MAX_BLOCKS])])
    else $error("granted block not marked taken");

endmodule

`default_nettype wire
